// File: rtl/core/sitdt_pkg.sv
// Constants and types shared by the signed integer to decimal text converter.
package sitdt_pkg;

   localparam int ValueW    = 32;               // input width
   localparam int CharW     = 6;                // ASCII code width on the output
   localparam int DigitW    = 4;                // one BCD digit
   localparam int NumDigits = 10;               // digits of the largest magnitude
   localparam int BcdW      = NumDigits * DigitW;
   localparam int BitCntW   = $clog2(ValueW);
   localparam int DigCntW   = $clog2(NumDigits + 1);

   localparam logic [CharW-1:0] MinusChar = 6'd45;
   // ASCII '0' is 6'b11_0000, so a digit below ten only fills the low nibble
   localparam logic [1:0]       DigitHigh = 2'b11;

   typedef logic [BcdW-1:0]   bcd_type;
   typedef logic [DigitW-1:0] digit_type;

endpackage

// File: rtl/core/signed_int_to_decimal_text.sv
// Signed 32-bit integer to decimal ASCII text, one character per output item.
//
// One input item is taken when the block is idle; the block is then busy until the last
// character has left. The magnitude is converted to ten BCD digits by a shift and
// add-three unit that handles one input bit per cycle, leading zero digits are then
// dropped one per cycle, and the text leaves at one character per cycle while rsp_tready
// is high: an optional '-' and 1 to 10 digits. The next item can be accepted in the cycle
// after the final character is taken. rsp_tlast marks the final character of each
// number. No state is kept between items.
module signed_int_to_decimal_text import sitdt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [ValueW-1:0] req_tdata,    // [31:0] value (signed)
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,    // [5:0] character, [7:6] zero
   output logic              rsp_tlast
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_TRIM,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [ValueW-1:0]  mag_ff, mag_in;
   bcd_type            bcd_ff, bcd_in;
   logic [BitCntW-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DigCntW-1:0] dig_cnt_ff, dig_cnt_in;
   logic               sign_ff, sign_in;

   bcd_type            bcd_adj;
   digit_type          top_digit;
   logic               req_accept;
   logic               rsp_accept;
   logic [CharW-1:0]   char_out;

   // Add three to every digit of five or more before the next shift.
   always_comb begin
      for (int d = 0; d < NumDigits; d++) begin
         if (bcd_ff[d*DigitW +: DigitW] >= digit_type'(5)) begin
            bcd_adj[d*DigitW +: DigitW] = bcd_ff[d*DigitW +: DigitW] + digit_type'(3);
         end else begin
            bcd_adj[d*DigitW +: DigitW] = bcd_ff[d*DigitW +: DigitW];
         end
      end
   end

   assign top_digit  = bcd_ff[BcdW-1 -: DigitW];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign char_out   = sign_ff ? MinusChar : {DigitHigh, top_digit};
   assign rsp_tdata  = {2'b00, char_out};
   assign rsp_tlast  = !sign_ff && (dig_cnt_ff == DigCntW'(1));

   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      sign_in    = sign_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               sign_in    = req_tdata[ValueW-1];
               mag_in     = req_tdata[ValueW-1] ? (ValueW'(0) - req_tdata) : req_tdata;
               bcd_in     = '0;
               bit_cnt_in = '0;
               dig_cnt_in = DigCntW'(NumDigits);
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            // shift the next magnitude bit into the adjusted digits
            bcd_in     = {bcd_adj[BcdW-2:0], mag_ff[ValueW-1]};
            mag_in     = {mag_ff[ValueW-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + BitCntW'(1);
            if (bit_cnt_ff == BitCntW'(ValueW - 1)) begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            // drop a leading zero digit, keep at least one
            if (top_digit == '0 && dig_cnt_ff != DigCntW'(1)) begin
               bcd_in     = {bcd_ff[BcdW-DigitW-1:0], digit_type'(0)};
               dig_cnt_in = dig_cnt_ff - DigCntW'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_accept) begin
               if (sign_ff) begin
                  sign_in = 1'b0;
               end else if (dig_cnt_ff == DigCntW'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  bcd_in     = {bcd_ff[BcdW-DigitW-1:0], digit_type'(0)};
                  dig_cnt_in = dig_cnt_ff - DigCntW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         sign_ff    <= 1'b0;
         dig_cnt_ff <= DigCntW'(1);
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         sign_ff    <= sign_in;
         dig_cnt_ff <= dig_cnt_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   // Never offer a character while taking a new number.
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("output valid while input ready");

   // Conversion and trimming lie between acceptance and output, so no character follows acceptance directly.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("character offered too early after acceptance");

   // The minus sign is never the final character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[5:0] != MinusChar))
      else $error("run ends on a minus sign");

   // Digits shown are always decimal.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !sign_ff) |-> (top_digit <= digit_type'(9)))
      else $error("non-decimal digit offered");

endmodule
